// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is low
`define SCW_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion, also checked during reset
`define SCW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/scw_pkg.sv =====
// ----------------------------------------------------------------------------
// scw_pkg
// Types, register indexes and saturation helper for the water column block.
// ----------------------------------------------------------------------------
package scw_pkg;

  typedef struct packed {
    logic              command;
    logic [5:0]        column;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } scw_in_t;

  typedef struct packed {
    logic [5:0]         column_index;
    logic signed [31:0] height;
    logic               last;
  } scw_out_t;

  typedef struct packed {
    logic h;
    logic s;
  } scw_wen_t;

  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_SPLASH = 1'b1;

  localparam logic [2:0] REG_TENSION      = 3'd0;
  localparam logic [2:0] REG_DAMPING      = 3'd1;
  localparam logic [2:0] REG_SPREAD       = 3'd2;
  localparam logic [2:0] REG_DRAG_X       = 3'd3;
  localparam logic [2:0] REG_DRAG_Y       = 3'd4;
  localparam logic [2:0] REG_REST_HEIGHT  = 3'd5;
  localparam logic [2:0] REG_COLUMN_COUNT = 3'd6;

  localparam logic [15:0] RST_TENSION      = 16'd1638;
  localparam logic [15:0] RST_DAMPING      = 16'd1638;
  localparam logic [15:0] RST_SPREAD       = 16'd16384;
  localparam logic [15:0] RST_DRAG_X       = 16'd655;
  localparam logic [15:0] RST_DRAG_Y       = 16'd1966;
  localparam logic [30:0] RST_REST_HEIGHT  = 31'd1310720;
  localparam logic [6:0]  RST_COLUMN_COUNT = 7'd20;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -36'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/scw_col_mem.sv =====
// ----------------------------------------------------------------------------
// scw_col_mem
// Height and speed storage, one read and one write port, registered reads.
// ----------------------------------------------------------------------------
module scw_col_mem
  import scw_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                clk,
  input  logic [AW-1:0]       rd_addr,
  output logic signed [31:0]  rd_h_r,
  output logic signed [31:0]  rd_s_r,
  input  scw_wen_t            wen,
  input  logic [AW-1:0]       wr_addr,
  input  logic signed [31:0]  wr_h,
  input  logic signed [31:0]  wr_s
);

  logic signed [31:0] h_mem [DEPTH];
  logic signed [31:0] s_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen.h) begin
      h_mem[wr_addr] <= wr_h;
    end
    rd_h_r <= h_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wen.s) begin
      s_mem[wr_addr] <= wr_s;
    end
    rd_s_r <= s_mem[rd_addr];
  end

endmodule

// ===== rtl/scw_gain_mul.sv =====
// ----------------------------------------------------------------------------
// scw_gain_mul
// Registered Q0.16 gain times signed value, floor-shifted right by 16.
// ----------------------------------------------------------------------------
module scw_gain_mul
  import scw_pkg::*;
(
  input  logic               clk,
  input  logic [15:0]        gain,
  input  logic signed [32:0] val,
  output logic signed [33:0] prod_r
);

  logic signed [49:0] full;

  assign full = $signed({1'b0, gain}) * val;

  always_ff @(posedge clk) begin
    prod_r <= full[49:16];
  end

endmodule

// ===== rtl/spring_column_wave_step.sv =====
// ----------------------------------------------------------------------------
// spring_column_wave_step
// Water surface of spring-coupled columns: tick, splash and height readout.
// ----------------------------------------------------------------------------
// A splash item updates the speed of one column. A tick item runs the spring
// step over the n columns in use, then the spread passes (none for a single
// column) and the readout (n = columns in use), plus output stall time: every
// column goes through the single read port and single write port of the column
// memory and one shared multiplier.
// After reset, and after any write of rest_height or column_count, a clearing
// pass over all MAX_COLUMNS columns runs before the next item is taken.
`include "assert_macros.svh"

module spring_column_wave_step
  import scw_pkg::*;
#(
  parameter int MAX_COLUMNS   = 64,
  parameter int SPREAD_PASSES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  scw_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output scw_out_t    out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int NW = $clog2(MAX_COLUMNS + 1);
  localparam int PW = $clog2(SPREAD_PASSES + 1);

  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_SPL_M1 = 5'd2;
  localparam logic [4:0] S_SPL_M2 = 5'd3;
  localparam logic [4:0] S_SPL_WB = 5'd4;
  localparam logic [4:0] S_SP_RD  = 5'd5;
  localparam logic [4:0] S_SP_M1  = 5'd6;
  localparam logic [4:0] S_SP_M2  = 5'd7;
  localparam logic [4:0] S_SP_WB  = 5'd8;
  localparam logic [4:0] S_PS_RD0 = 5'd9;
  localparam logic [4:0] S_PS_LD0 = 5'd10;
  localparam logic [4:0] S_PS_NX  = 5'd11;
  localparam logic [4:0] S_PS_M1  = 5'd12;
  localparam logic [4:0] S_PS_WB  = 5'd13;
  localparam logic [4:0] S_OUT_RD = 5'd14;
  localparam logic [4:0] S_OUT_LD = 5'd15;
  localparam logic [4:0] S_OUT_W  = 5'd16;

  logic [4:0]  state_r;
  logic [15:0] tension_r, damping_r, spread_r, drag_x_r, drag_y_r;
  logic [30:0] rest_r;
  logic [6:0]  count_r;
  logic [NW-1:0] col_r;
  logic [PW-1:0] pass_r;
  logic          out_valid_r;
  scw_out_t      out_r;

  logic signed [32:0] absx_r, absy_r;
  logic signed [35:0] acc_r;
  logic signed [31:0] cur_h_r, cur_s_r, next_h_r, next_s_r, prev_r, dr_r;

  logic [NW-1:0]      n_cols;
  logic [NW:0]        col_p1, col_p2;
  logic               is_last_col;
  logic [AW-1:0]      rd_addr;
  logic signed [31:0] rd_h, rd_s;
  scw_wen_t           wen;
  logic signed [31:0] wr_h, wr_s;
  logic [15:0]        mul_gain;
  logic signed [32:0] mul_val;
  logic signed [33:0] prod;
  logic signed [31:0] s_sp, s_tmp, h_tmp, dl;
  logic               in_acc;
  logic               cfg_clr;

  always_comb begin
    if (count_r == 7'd0) begin
      n_cols = NW'(1);
    end else if (32'(count_r) > 32'(MAX_COLUMNS)) begin
      n_cols = NW'(MAX_COLUMNS);
    end else begin
      n_cols = NW'(count_r);
    end
  end

  assign col_p1      = (NW+1)'(col_r) + (NW+1)'(1);
  assign col_p2      = (NW+1)'(col_r) + (NW+1)'(2);
  assign is_last_col = (col_p1 == (NW+1)'(n_cols));
  assign in_stall    = (state_r != S_IDLE);
  assign in_acc      = in_valid && !in_stall;
  assign out_valid   = out_valid_r;
  assign out_data    = out_r;
  assign cfg_clr     = cfg_we &&
                       (cfg_index == REG_REST_HEIGHT || cfg_index == REG_COLUMN_COUNT);

  always_comb begin
    unique case (state_r)
      S_PS_LD0: rd_addr = col_p1[AW-1:0];
      S_PS_WB:  rd_addr = col_p2[AW-1:0];
      default:  rd_addr = col_r[AW-1:0];
    endcase
  end

  always_comb begin
    mul_gain = spread_r;
    mul_val  = 33'(sat32(36'(next_h_r) - 36'(cur_h_r)));
    unique case (state_r)
      S_SPL_M1: begin
        mul_gain = drag_x_r;
        mul_val  = absx_r;
      end
      S_SPL_M2: begin
        mul_gain = drag_y_r;
        mul_val  = absy_r;
      end
      S_SP_M1: begin
        mul_gain = tension_r;
        mul_val  = 33'(sat32(36'($signed({1'b0, rest_r})) - 36'(rd_h)));
      end
      S_SP_M2: begin
        mul_gain = damping_r;
        mul_val  = 33'(cur_s_r);
      end
      S_PS_NX: begin
        mul_gain = spread_r;
        mul_val  = 33'(sat32(36'(prev_r) - 36'(cur_h_r)));
      end
      default: begin
        mul_gain = spread_r;
        mul_val  = 33'(sat32(36'(next_h_r) - 36'(cur_h_r)));
      end
    endcase
  end

  assign s_sp  = sat32(acc_r - 36'(prod));
  assign dl    = is_last_col ? 32'sd0 : prod[31:0];
  assign s_tmp = sat32(36'(cur_s_r) + 36'(dr_r));
  assign h_tmp = sat32(36'(cur_h_r) + 36'(dr_r));

  always_comb begin
    wen  = '0;
    wr_h = sat32(36'(h_tmp) + 36'(dl));
    wr_s = sat32(36'(s_tmp) + 36'(dl));
    unique case (state_r)
      S_CLR: begin
        wen  = '{h: 1'b1, s: 1'b1};
        wr_h = $signed({1'b0, rest_r});
        wr_s = 32'sd0;
      end
      S_SPL_WB: begin
        wen.s = 1'b1;
        wr_s  = sat32(acc_r + 36'(prod));
      end
      S_SP_WB: begin
        wen  = '{h: 1'b1, s: 1'b1};
        wr_s = s_sp;
        wr_h = sat32(36'(cur_h_r) + 36'(s_sp));
      end
      S_PS_WB: begin
        wen = '{h: 1'b1, s: 1'b1};
      end
      default: begin
        wen = '0;
      end
    endcase
  end

  scw_col_mem #(.DEPTH(MAX_COLUMNS), .AW(AW)) u_mem (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_h_r  (rd_h),
    .rd_s_r  (rd_s),
    .wen     (wen),
    .wr_addr (col_r[AW-1:0]),
    .wr_h    (wr_h),
    .wr_s    (wr_s)
  );

  scw_gain_mul u_mul (
    .clk    (clk),
    .gain   (mul_gain),
    .val    (mul_val),
    .prod_r (prod)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      col_r       <= '0;
      pass_r      <= '0;
      out_valid_r <= 1'b0;
      tension_r   <= RST_TENSION;
      damping_r   <= RST_DAMPING;
      spread_r    <= RST_SPREAD;
      drag_x_r    <= RST_DRAG_X;
      drag_y_r    <= RST_DRAG_Y;
      rest_r      <= RST_REST_HEIGHT;
      count_r     <= RST_COLUMN_COUNT;
    end else begin
      if (cfg_clr) begin
        col_r       <= '0;
        out_valid_r <= 1'b0;
        state_r     <= S_CLR;
      end else begin
        unique case (state_r)
          S_CLR: begin
            if (32'(col_r) == MAX_COLUMNS - 1) begin
              col_r   <= '0;
              state_r <= S_IDLE;
            end else begin
              col_r <= NW'(col_p1);
            end
          end
          S_IDLE: begin
            if (in_acc) begin
              if (in_data.command == CMD_TICK) begin
                col_r   <= '0;
                state_r <= S_SP_RD;
              end else if (32'(in_data.column) < 32'(n_cols)) begin
                col_r   <= NW'(in_data.column);
                absx_r  <= in_data.vel_x[31] ? -33'(in_data.vel_x) : 33'(in_data.vel_x);
                absy_r  <= in_data.vel_y[31] ? -33'(in_data.vel_y) : 33'(in_data.vel_y);
                state_r <= S_SPL_M1;
              end
            end
          end
          S_SPL_M1: state_r <= S_SPL_M2;
          S_SPL_M2: begin
            acc_r   <= 36'(prod);
            state_r <= S_SPL_WB;
          end
          S_SPL_WB: begin
            col_r   <= '0;
            state_r <= S_IDLE;
          end
          S_SP_RD: state_r <= S_SP_M1;
          S_SP_M1: begin
            cur_h_r <= rd_h;
            cur_s_r <= rd_s;
            state_r <= S_SP_M2;
          end
          S_SP_M2: begin
            acc_r   <= 36'(cur_s_r) + 36'(prod);
            state_r <= S_SP_WB;
          end
          S_SP_WB: begin
            if (is_last_col) begin
              col_r   <= '0;
              pass_r  <= '0;
              state_r <= (n_cols == NW'(1)) ? S_OUT_RD : S_PS_RD0;
            end else begin
              col_r   <= NW'(col_p1);
              state_r <= S_SP_RD;
            end
          end
          S_PS_RD0: state_r <= S_PS_LD0;
          S_PS_LD0: begin
            cur_h_r <= rd_h;
            cur_s_r <= rd_s;
            state_r <= S_PS_NX;
          end
          S_PS_NX: begin
            next_h_r <= rd_h;
            next_s_r <= rd_s;
            state_r  <= S_PS_M1;
          end
          S_PS_M1: begin
            dr_r    <= (col_r == '0) ? 32'sd0 : prod[31:0];
            state_r <= S_PS_WB;
          end
          S_PS_WB: begin
            prev_r  <= cur_h_r;
            cur_h_r <= next_h_r;
            cur_s_r <= next_s_r;
            if (is_last_col) begin
              col_r <= '0;
              if (32'(pass_r) == SPREAD_PASSES - 1) begin
                state_r <= S_OUT_RD;
              end else begin
                pass_r  <= PW'(32'(pass_r) + 1);
                state_r <= S_PS_RD0;
              end
            end else begin
              col_r   <= NW'(col_p1);
              state_r <= S_PS_NX;
            end
          end
          S_OUT_RD: state_r <= S_OUT_LD;
          S_OUT_LD: begin
            out_r.column_index <= 6'(32'(col_r));
            out_r.height       <= rd_h;
            out_r.last         <= is_last_col;
            out_valid_r        <= 1'b1;
            state_r            <= S_OUT_W;
          end
          S_OUT_W: begin
            if (!out_stall) begin
              out_valid_r <= 1'b0;
              if (is_last_col) begin
                col_r   <= '0;
                state_r <= S_IDLE;
              end else begin
                col_r   <= NW'(col_p1);
                state_r <= S_OUT_RD;
              end
            end
          end
          default: state_r <= S_CLR;
        endcase
      end

      if (cfg_we) begin
        unique case (cfg_index)
          REG_TENSION:      tension_r <= cfg_data[15:0];
          REG_DAMPING:      damping_r <= cfg_data[15:0];
          REG_SPREAD:       spread_r  <= cfg_data[15:0];
          REG_DRAG_X:       drag_x_r  <= cfg_data[15:0];
          REG_DRAG_Y:       drag_y_r  <= cfg_data[15:0];
          REG_REST_HEIGHT:  rest_r    <= cfg_data;
          REG_COLUMN_COUNT: count_r   <= cfg_data[6:0];
          default: ;
        endcase
      end
    end
  end

  `SCW_ASSERT(a_out_only_in_wait, clk, rst_n, out_valid_r |-> (state_r == S_OUT_W), "result shown outside output wait")
  `SCW_ASSERT(a_tick_starts_spring, clk, rst_n, (in_acc && !cfg_we && in_data.command == CMD_TICK) |=> (state_r == S_SP_RD), "tick item did not start spring step")
  `SCW_ASSERT(a_last_is_final_col, clk, rst_n, (out_valid_r && out_r.last) |-> is_last_col, "last flag on a column that is not final")
  `SCW_ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> (state_r == S_CLR && !out_valid_r), "reset did not start clearing pass")

endmodule
